@@ hw/rtl/smsp_pkg.sv @@
`default_nettype none
package smsp_pkg;

    localparam int CHANNELS  = 64;
    localparam int MAX_PULSE = 8;

    localparam int CH_W    = 6;
    localparam int LEVEL_W = 16;
    localparam int SCALE_W = 12;
    localparam int PLEN_W  = 8;
    localparam int MS_W    = 12;
    localparam int PULSE_W = 4;
    localparam int MV_W    = 16;
    localparam int PROD_W  = LEVEL_W + SCALE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [MV_W-1:0]    IDLE_MV   = 16'd600;
    localparam logic [MS_W-1:0]    SINCE_MAX = 12'hFFF;

    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 16'd20;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 16'd300;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 12'd256;
    localparam logic [PLEN_W-1:0]  PLEN_RST      = 8'd1;
    localparam logic [MS_W-1:0]    TIMEOUT_RST   = 12'd1000;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_MS    = 2'd1,
        MODE_PULSE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEVEL = 3'd0,
        CFG_MAX_LEVEL = 3'd1,
        CFG_SCALE     = 3'd2,
        CFG_PLEN      = 3'd3,
        CFG_TIMEOUT   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_LEVEL = 2'd1,
        ST_OFF   = 2'd2,
        ST_ON    = 2'd3
    } t_state;

    typedef struct packed {
        logic accept;    // take the input transaction
        logic look;      // evaluate the fetched table entry
        logic load_off;  // push an off result into the output register
        logic load_on;   // push an on result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic tick;      // pending input is a millisecond tick
        logic pulse_end; // pending input is a pulse tick that ends the pulse
        logic off_pend;  // an off result is owed for the current transaction
        logic fire;      // visited channel fires
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage
`default_nettype wire

@@ hw/rtl/smsp_ctrl.sv @@
`default_nettype none
module smsp_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  smsp_pkg::t_dp_stat     i_stat,
    output smsp_pkg::t_dp_cmd      o_cmd
);
    import smsp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.tick) begin
                        n_state = ST_LEVEL;
                    end else if (i_stat.pulse_end) begin
                        n_state = ST_OFF;
                    end
                end
            end
            ST_LEVEL: begin
                o_cmd.look = 1'b1;
                n_state    = ST_OFF;
            end
            ST_OFF: begin
                if (!i_stat.off_pend) begin
                    n_state = i_stat.fire ? ST_ON : ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.load_off = 1'b1;
                    n_state        = i_stat.fire ? ST_ON : ST_IDLE;
                end
            end
            ST_ON: begin
                if (i_stat.out_free) begin
                    o_cmd.load_on = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // a table lookup only ever directly follows an accepted tick
    a_look_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.look |-> $past(o_cmd.accept))
        else $error("table lookup without a preceding tick");

endmodule
`default_nettype wire

@@ hw/rtl/smsp_dp.sv @@
`default_nettype none
module smsp_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // config
    input  wire                                  i_cfg_we,
    input  wire  [smsp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [smsp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input fields
    input  wire  [1:0]                           i_mode,
    input  wire  [smsp_pkg::CH_W-1:0]            i_entry_index,
    input  wire  [smsp_pkg::LEVEL_W-1:0]         i_entry_level,
    // result register
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output logic [smsp_pkg::CH_W-1:0]            o_channel,
    output logic                                 o_channel_on,
    output logic [smsp_pkg::MV_W-1:0]            o_dac_mv,
    output logic                                 o_last,
    // control
    input  smsp_pkg::t_dp_cmd                    i_cmd,
    output smsp_pkg::t_dp_stat                   o_stat
);
    import smsp_pkg::*;

    // config registers
    logic [LEVEL_W-1:0] r_min_level;
    logic [LEVEL_W-1:0] r_max_level;
    logic [SCALE_W-1:0] r_scale;
    logic [PLEN_W-1:0]  r_plen;
    logic [MS_W-1:0]    r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level <= MIN_LEVEL_RST;
            r_max_level <= MAX_LEVEL_RST;
            r_scale     <= SCALE_RST;
            r_plen      <= PLEN_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_LEVEL: r_min_level <= i_cfg_data;
                CFG_MAX_LEVEL: r_max_level <= i_cfg_data;
                CFG_SCALE:     r_scale     <= i_cfg_data[SCALE_W-1:0];
                CFG_PLEN:      r_plen      <= i_cfg_data[PLEN_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // scan state
    logic                r_active;
    logic [MS_W-1:0]     r_since;
    logic [CH_W-1:0]     r_ptr;
    logic                r_live_valid;
    logic [CH_W-1:0]     r_live_ch;
    logic [PULSE_W-1:0]  r_pulse_left;
    logic [CHANNELS-1:0] r_valid;
    logic                r_off_pend;
    logic                r_fire;
    logic [CH_W-1:0]     r_ch;
    logic                r_rd_vld;
    logic [LEVEL_W-1:0]  r_rd_data;
    logic [PROD_W-1:0]   r_prod;
    logic [LEVEL_W-1:0]  mem [CHANNELS];

    logic                is_write, is_tick, is_pulse;
    logic                wr_ok;
    logic [MS_W-1:0]     since_n;
    logic                clear_n;
    logic                active_n;
    logic [CH_W-1:0]     ch_sel;
    logic [CH_W-1:0]     ptr_inc;
    logic [CH_W-1:0]     ptr_n;
    logic                pulse_end;
    logic [LEVEL_W-1:0]  level;
    logic                fire_n;
    logic [PULSE_W-1:0]  pulse_init;
    logic [MV_W+4:0]     mv_sum;
    logic [MV_W-1:0]     mv_on;
    logic                out_free;

    always_comb begin
        is_write = i_mode == MODE_WRITE;
        is_tick  = i_mode == MODE_MS;
        is_pulse = i_mode == MODE_PULSE;
        wr_ok    = is_write && ({1'b0, i_entry_index} < (CH_W+1)'(CHANNELS));

        since_n  = (r_since == SINCE_MAX) ? r_since : r_since + 1'b1;
        clear_n  = r_active && (since_n > r_timeout);
        active_n = r_active && !clear_n;

        ch_sel   = ({1'b0, r_ptr} >= (CH_W+1)'(CHANNELS)) ? '0 : r_ptr;
        ptr_inc  = ch_sel + 1'b1;
        ptr_n    = ({1'b0, ch_sel} + 1'b1 >= (CH_W+1)'(CHANNELS)) ? '0 : ptr_inc;

        pulse_end = is_pulse && (r_pulse_left == PULSE_W'(1)) && r_live_valid;

        level  = r_rd_vld ? r_rd_data : '0;
        fire_n = r_active && (level > r_min_level) && (level <= r_max_level);

        if (r_plen == '0) begin
            pulse_init = PULSE_W'(1);
        end else if (r_plen > PLEN_W'(MAX_PULSE)) begin
            pulse_init = PULSE_W'(MAX_PULSE);
        end else begin
            pulse_init = r_plen[PULSE_W-1:0];
        end

        mv_sum = (MV_W+5)'(IDLE_MV) + {1'b0, r_prod[PROD_W-1:8]};
        mv_on  = (mv_sum > (MV_W+5)'(16'hFFFF)) ? 16'hFFFF : mv_sum[MV_W-1:0];

        out_free = !o_out_valid || i_out_ready;

        o_stat.tick      = is_tick;
        o_stat.pulse_end = pulse_end;
        o_stat.off_pend  = r_off_pend;
        o_stat.fire      = r_fire;
        o_stat.out_free  = out_free;
    end

    // level table: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_ok) begin
            mem[i_entry_index] <= i_entry_level;
        end
        r_rd_data <= mem[ch_sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_since      <= '0;
            r_ptr        <= '0;
            r_live_valid <= 1'b0;
            r_live_ch    <= '0;
            r_pulse_left <= '0;
            r_valid      <= '0;
            r_off_pend   <= 1'b0;
            r_fire       <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_fire     <= 1'b0;
                r_off_pend <= (is_tick && r_live_valid) || pulse_end;
                if (wr_ok) begin
                    r_valid[i_entry_index] <= 1'b1;
                    r_active               <= 1'b1;
                    r_since                <= '0;
                end
                if (is_tick) begin
                    r_since      <= since_n;
                    r_active     <= active_n;
                    r_live_valid <= 1'b0;
                    r_pulse_left <= '0;
                    if (clear_n) begin
                        r_valid <= '0;
                    end
                    if (active_n) begin
                        r_ptr <= ptr_n;
                    end
                end
                if (is_pulse && r_pulse_left != '0) begin
                    r_pulse_left <= r_pulse_left - 1'b1;
                    if (pulse_end) begin
                        r_live_valid <= 1'b0;
                    end
                end
            end
            if (i_cmd.look) begin
                r_fire <= fire_n;
            end
            if (i_cmd.load_on) begin
                r_live_valid <= 1'b1;
                r_live_ch    <= r_ch;
                r_pulse_left <= pulse_init;
            end
        end
    end

    // payload side registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch     <= ch_sel;
            r_rd_vld <= r_valid[ch_sel];
        end
        if (i_cmd.look) begin
            r_prod <= level * r_scale;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_off || i_cmd.load_on) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_off) begin
            o_channel    <= r_live_ch;
            o_channel_on <= 1'b0;
            o_dac_mv     <= IDLE_MV;
            o_last       <= !r_fire;
        end else if (i_cmd.load_on) begin
            o_channel    <= r_ch;
            o_channel_on <= 1'b1;
            o_dac_mv     <= mv_on;
            o_last       <= 1'b1;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_off || i_cmd.load_on) |-> out_free)
        else $error("result loaded over an untaken result");

    a_pulse_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pulse_left != '0) == r_live_valid)
        else $error("pulse counter and live channel disagree");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && is_tick && clear_n) |=> (!r_active && r_valid == '0))
        else $error("timeout did not clear the table");

endmodule
`default_nettype wire

@@ hw/rtl/stim_matrix_scan_pulser.sv @@
`default_nettype none
// Sequence: a table write is taken and gives no result; a millisecond tick goes
//   through the table lookup, then its off result, then its on result; a pulse
//   tick that ends a pulse goes straight to its off result.
// Flow: input is taken only in the idle state, so a new item waits until the last
//   is through; an output stall holds the controller until the register is free.
// Reset: i_rst_n synchronous, active low; table reads as zero, registers at defaults.
module stim_matrix_scan_pulser (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // input stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [5:0] entry_index, [21:6] entry_level, [23:22] zero
    input  wire  [smsp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] mode
    input  wire  [1:0]                            s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // [5:0] channel, [6] channel_on, [22:7] dac_mv, [23] zero
    output logic [smsp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,
    // config write channel
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [smsp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [smsp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import smsp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic [CH_W-1:0] out_channel;
    logic            out_on;
    logic [MV_W-1:0] out_mv;

    // Config registers are plain flops, so a write always lands at once.
    assign o_cfg_ready = 1'b1;

    // Controller: idle -> (tick) table lookup -> off result -> on result.
    // Table writes finish in the accepting cycle; a pulse end goes straight
    // to the off result.
    smsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: level table with valid bits (timeout clear drops them all at
    // once), scan pointer, timeout counter, pulse counter, DAC scaling
    // multiply and the output register that decouples the result stream.
    smsp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (s_axis_tuser),
        .i_entry_index (s_axis_tdata[CH_W-1:0]),
        .i_entry_level (s_axis_tdata[CH_W+LEVEL_W-1:CH_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_channel     (out_channel),
        .o_channel_on  (out_on),
        .o_dac_mv      (out_mv),
        .o_last        (m_axis_tlast),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

    // pack result fields, low field first, padded to whole bytes
    assign m_axis_tdata = {1'b0, out_mv, out_on, out_channel};

endmodule
`default_nettype wire

@@ bench/stim_matrix_scan_pulser_test.sv @@
`timescale 1ns / 100ps
// Scan pulser bench: every input transaction is mirrored in a local scanner
// model that predicts the on/off switch results; the output stream is checked
// against the queue of predicted switches in arrival order.
module stim_matrix_scan_pulser_test;
    import smsp_pkg::*;

    localparam int QUIET_LIMIT   = 5000; // cycles without any transaction
    localparam int SETTLE_CYCLES = 100;  // idle time after the last owed switch
    localparam int HOLD_CYCLES   = 300;  // long receiver stall
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 150;

    // one switch result, fields in the order of m_axis_tdata plus tlast
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            on;
        logic [MV_W-1:0] mv;
        logic            last;
    } t_switch;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    stim_matrix_scan_pulser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Scanner model state and register copies
    // ---------------------------------------------------------------
    logic [LEVEL_W-1:0] level_mem [CHANNELS];
    bit                 tbl_active;
    logic [MS_W-1:0]    ms_since;
    logic [CH_W-1:0]    scan_ptr;
    bit                 live;
    logic [CH_W-1:0]    live_ch;
    logic [PULSE_W-1:0] pulses_left;

    logic [LEVEL_W-1:0] cfg_min;
    logic [LEVEL_W-1:0] cfg_max;
    logic [SCALE_W-1:0] cfg_scale;
    logic [PLEN_W-1:0]  cfg_plen;
    logic [MS_W-1:0]    cfg_timeout;

    t_switch expected_switches[$];

    // run bookkeeping
    int  items_sent       = 0;
    int  switches_checked = 0;
    int  mismatches       = 0;
    int  table_clears     = 0;
    int  config_rounds    = 0;
    int  quiet_cycles     = 0;
    bit  idle_on          = 1'b1;  // random idling on both sides
    bit  rx_hold          = 1'b0;  // long receiver stall in progress
    int  rx_gap           = 0;

    task automatic reset_scanner();
        foreach (level_mem[i]) level_mem[i] = '0;
        tbl_active  = 1'b0;
        ms_since    = '0;
        scan_ptr    = '0;
        live        = 1'b0;
        live_ch     = '0;
        pulses_left = '0;
        cfg_min     = MIN_LEVEL_RST;
        cfg_max     = MAX_LEVEL_RST;
        cfg_scale   = SCALE_RST;
        cfg_plen    = PLEN_RST;
        cfg_timeout = TIMEOUT_RST;
    endtask

    // Advance the scanner by one accepted transaction and queue the switches
    // it owes, in output order.
    task automatic advance_scanner(t_mode mode, logic [CH_W-1:0] idx,
                                   logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] lvl;
        logic [CH_W-1:0]    ch;
        logic [CH_W-1:0]    off_ch;
        bit                 had_off;
        bit                 fires;
        int unsigned        mv;
        int unsigned        plen;
        had_off = 1'b0;
        fires   = 1'b0;
        lvl     = '0;
        ch      = '0;
        off_ch  = '0;
        case (mode)
            MODE_WRITE: begin
                level_mem[idx] = level;
                tbl_active     = 1'b1;
                ms_since       = '0;
            end
            MODE_PULSE: begin
                if (pulses_left != 0) begin
                    pulses_left = pulses_left - 1'b1;
                    if (pulses_left == 0 && live) begin
                        expected_switches.push_back('{live_ch, 1'b0, IDLE_MV, 1'b1});
                        live = 1'b0;
                    end
                end
            end
            MODE_MS: begin
                if (ms_since != SINCE_MAX) ms_since = ms_since + 1'b1;
                // stale table: wipe it before anything else
                if (tbl_active && ms_since > cfg_timeout) begin
                    foreach (level_mem[i]) level_mem[i] = '0;
                    tbl_active = 1'b0;
                    table_clears++;
                end
                if (live) begin
                    had_off     = 1'b1;
                    off_ch      = live_ch;
                    live        = 1'b0;
                    pulses_left = '0;
                end
                if (tbl_active) begin
                    ch       = scan_ptr;
                    scan_ptr = (scan_ptr == CH_W'(CHANNELS - 1)) ? '0 : scan_ptr + 1'b1;
                    lvl      = level_mem[ch];
                    fires    = (lvl > cfg_min) && (lvl <= cfg_max);
                end
                // the off result is only last when no on result follows
                if (had_off)
                    expected_switches.push_back('{off_ch, 1'b0, IDLE_MV, !fires});
                if (fires) begin
                    mv = 32'(IDLE_MV) + ((32'(lvl) * 32'(cfg_scale)) >> 8);
                    if (mv > 32'hFFFF) mv = 32'hFFFF;
                    expected_switches.push_back('{ch, 1'b1, MV_W'(mv), 1'b1});
                    live    = 1'b1;
                    live_ch = ch;
                    plen    = cfg_plen;
                    if (plen == 0) plen = 1;
                    if (plen > MAX_PULSE) plen = MAX_PULSE;
                    pulses_left = PULSE_W'(plen);
                end
            end
            default: ; // unused mode: no effect at all
        endcase
    endtask

    // ---------------------------------------------------------------
    // Receiver side: random ready bursts, plus the long hold on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap        <= rx_gap - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap        <= $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker: every output transaction against the oldest switch
    // ---------------------------------------------------------------
    task automatic note_mismatch(string what, t_switch want, t_switch seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): ch %0d/%0d on %0b/%0b mv %0d/%0d last %0b/%0b",
                     $realtime, what, want.channel, seen.channel, want.on, seen.on,
                     want.mv, seen.mv, want.last, seen.last);
    endtask

    always @(posedge i_clk) begin : check_switch
        t_switch seen;
        t_switch want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = '{m_axis_tdata[5:0], m_axis_tdata[6], m_axis_tdata[22:7], m_axis_tlast};
            switches_checked++;
            if (expected_switches.size() == 0) begin
                note_mismatch("unexpected switch, exp/act", seen, seen);
            end else begin
                want = expected_switches.pop_front();
                if (seen.channel !== want.channel || seen.on !== want.on ||
                    seen.mv !== want.mv || seen.last !== want.last)
                    note_mismatch("field, exp/act", want, seen);
            end
        end
    end

    // Watchdog: any transaction on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d switches pending",
                     quiet_cycles, expected_switches.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // One input transaction; tvalid stays high on return so back-to-back
    // items need no extra edge.
    task automatic send_item(t_mode mode, logic [CH_W-1:0] idx, logic [LEVEL_W-1:0] level);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, level, idx};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_scanner(mode, idx, level);
        items_sent++;
    endtask

    // ticks and unused modes carry random don't-care payload
    task automatic send_tick(t_mode mode);
        send_item(mode, CH_W'($urandom), LEVEL_W'($urandom));
    endtask

    // Stop sending, wait for all owed switches, then let the block go idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_switches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_LEVEL: cfg_min     = data;
            CFG_MAX_LEVEL: cfg_max     = data;
            CFG_SCALE:     cfg_scale   = data[SCALE_W-1:0];
            CFG_PLEN:      cfg_plen    = data[PLEN_W-1:0];
            CFG_TIMEOUT:   cfg_timeout = data[MS_W-1:0];
            default: ;
        endcase
    endtask

    // Full register set; bits above a register's width are dropped by the block.
    task automatic set_config(logic [15:0] min_d, logic [15:0] max_d, logic [15:0] scale_d,
                              logic [15:0] plen_d, logic [15:0] timeout_d);
        write_reg(CFG_MIN_LEVEL, min_d);
        write_reg(CFG_MAX_LEVEL, max_d);
        write_reg(CFG_SCALE, scale_d);
        write_reg(CFG_PLEN, plen_d);
        write_reg(CFG_TIMEOUT, timeout_d);
        i_cfg_valid <= 1'b0;
        config_rounds++;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        if (cfg_min < cfg_max && $urandom_range(0, 9) < 7)
            return LEVEL_W'($urandom_range(int'(cfg_min) + 1, int'(cfg_max)));
        case ($urandom_range(0, 4))
            0:       return cfg_min;
            1:       return cfg_min + 1'b1;
            2:       return cfg_max;
            3:       return cfg_max + 1'b1;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset registers: ignored inputs, then the level window edges.
    task automatic test_scan_window_edges();
        send_tick(MODE_NONE);             // unused mode
        send_tick(MODE_PULSE);            // no pulse running
        send_tick(MODE_MS);               // inactive table, pointer stays
        send_item(MODE_WRITE, 6'd0, 16'd21);   // just above min
        send_item(MODE_WRITE, 6'd1, 16'd20);   // at min: skipped
        send_item(MODE_WRITE, 6'd2, 16'd300);  // at max: fires
        send_item(MODE_WRITE, 6'd3, 16'd301);  // above max: skipped
        send_tick(MODE_MS);               // ch0 on
        send_tick(MODE_MS);               // ch0 off, ch1 skipped
        send_tick(MODE_MS);               // ch2 on
        send_tick(MODE_PULSE);            // single pulse ends: ch2 off
        send_tick(MODE_MS);               // ch3 skipped
        send_tick(MODE_PULSE);
        settle();
    endtask

    // Register extremes: full window, top scale, pulse clamps, saturated DAC.
    task automatic test_register_extremes();
        set_config(16'd0, 16'hFFFF, 16'd4095, 16'd255, 16'd1000);
        send_item(MODE_WRITE, scan_ptr, 16'd1);
        send_item(MODE_WRITE, 6'd63, 16'hFFFF);  // top index, saturates dac_mv
        // walk the pointer round to the top channel and back to zero
        do send_tick(MODE_MS); while (scan_ptr != 0);
        repeat (9) send_tick(MODE_PULSE);        // length 255 clamps to 8
        settle();
        // zero scale and zero length (clamps to 1); upper data bits set
        set_config(16'd0, 16'hFFFF, 16'hF000, 16'hFF00, 16'hF000 | 16'd1000);
        send_item(MODE_WRITE, scan_ptr, 16'd40000);
        send_tick(MODE_MS);
        send_tick(MODE_PULSE);
        settle();
        // empty windows: min equal to max, then min above max
        set_config(16'd300, 16'd300, 16'd256, 16'd1, 16'd1000);
        send_item(MODE_WRITE, scan_ptr, 16'd300);
        send_tick(MODE_MS);
        settle();
        set_config(16'd500, 16'd100, 16'd256, 16'd1, 16'd1000);
        send_item(MODE_WRITE, scan_ptr, 16'd300);
        send_tick(MODE_MS);
        settle();
    endtask

    // Timeout expiry with a live channel, then the zero timeout.
    task automatic test_timeout_clear();
        set_config(16'd0, 16'hFFFF, 16'd256, 16'd3, 16'd1);
        send_item(MODE_WRITE, scan_ptr, 16'd50);
        send_item(MODE_WRITE, scan_ptr + 1'b1, 16'd60);
        send_tick(MODE_MS);              // fires
        send_tick(MODE_MS);              // expired: cleared, live channel off
        send_tick(MODE_MS);              // inactive
        send_item(MODE_WRITE, scan_ptr, 16'd70);
        send_tick(MODE_MS);
        repeat (3) send_tick(MODE_PULSE);
        settle();
        set_config(16'd0, 16'hFFFF, 16'd256, 16'd1, 16'd0);
        send_item(MODE_WRITE, scan_ptr, 16'd80);
        send_tick(MODE_MS);              // first tick already expires
        send_tick(MODE_MS);
        settle();
    endtask

    // Timeout 4095 holds the table through a long run of ticks; a later
    // short timeout clears it on the next tick.
    task automatic test_timeout_saturation();
        set_config(16'hFFFF, 16'd0, 16'd256, 16'd1, 16'd4095);
        for (int i = 0; i < CHANNELS; i++) send_item(MODE_WRITE, CH_W'(i), 16'd100);
        repeat (200) send_tick(MODE_MS);
        settle();
        set_config(16'd0, 16'hFFFF, 16'd256, 16'd1, 16'd100);
        send_tick(MODE_MS);
        send_tick(MODE_MS);
        settle();
    endtask

    // Receiver holds off while ticks keep coming, filling the block.
    task automatic test_output_backpressure();
        set_config(16'd0, 16'hFFFF, 16'd300, 16'd8, 16'd4095);
        for (int i = 0; i < CHANNELS; i++)
            send_item(MODE_WRITE, CH_W'(i), LEVEL_W'($urandom_range(1, 65535)));
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (40) send_tick(MODE_MS);
        settle();
    endtask

    // Mostly well-formed scan rounds with random content, some noise;
    // the final phase runs with no idling.
    task automatic test_random_traffic();
        logic [15:0] min_d, max_d, scale_d, plen_d, timeout_d;
        int          target;
        for (int phase = 0; phase < PHASES; phase++) begin
            idle_on <= (phase != PHASES - 1);
            case ($urandom_range(0, 5))
                0:       min_d = 16'd0;
                1:       min_d = 16'hFFFF;
                default: min_d = 16'($urandom_range(0, 200));
            endcase
            case ($urandom_range(0, 5))
                0:       max_d = 16'hFFFF;
                1:       max_d = 16'd0;
                default: max_d = 16'($urandom_range(150, 3000));
            endcase
            case ($urandom_range(0, 3))
                0:       scale_d = 16'd0;
                1:       scale_d = 16'd4095;
                default: scale_d = 16'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 3))
                0:       plen_d = 16'd0;
                1:       plen_d = 16'd255;
                default: plen_d = 16'($urandom_range(1, 9));
            endcase
            case ($urandom_range(0, 3))
                0:       timeout_d = 16'd4095;
                1:       timeout_d = 16'd0;
                default: timeout_d = 16'($urandom_range(1, 40));
            endcase
            // random junk above each register's width
            scale_d   = scale_d | (16'($urandom_range(0, 15)) << 12);
            plen_d    = plen_d | (16'($urandom_range(0, 255)) << 8);
            timeout_d = timeout_d | (16'($urandom_range(0, 15)) << 12);
            set_config(min_d, max_d, scale_d, plen_d, timeout_d);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 4) != 0) begin
                    // writes just ahead of the scan pointer, one tick, some pulses
                    repeat ($urandom_range(0, 4))
                        send_item(MODE_WRITE, scan_ptr + CH_W'($urandom_range(0, 3)),
                                  pick_level());
                    send_tick(MODE_MS);
                    repeat ($urandom_range(0, 9)) send_tick(MODE_PULSE);
                end else begin
                    send_item(t_mode'($urandom_range(0, 3)), CH_W'($urandom),
                              LEVEL_W'($urandom));
                end
            end
            settle();
        end
    endtask

    initial begin
        reset_scanner();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_scan_window_edges();
        test_register_extremes();
        test_timeout_clear();
        test_timeout_saturation();
        test_output_backpressure();
        test_random_traffic();
        settle();

        $display("Run covered %0d input transactions, %0d switch results, %0d register sets,",
                 items_sent, switches_checked, config_rounds);
        $display("%0d timeout clears of the level table and one long output stall.",
                 table_clears);
        if (mismatches == 0 && expected_switches.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d switches never seen", mismatches,
                     expected_switches.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
